// ===== design/first_fit_free_list_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_macros
// Assertion helpers for the free-list allocator.
// Each macro expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define FFA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define FFA_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== design/ffa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and types of the first-fit free-list allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

	// Register indexes of the configuration port
	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Allocation constants
	localparam logic [31:0] MIN_REQUEST  = 32'd12;
	localparam logic [31:0] HEADER_BYTES = 32'd4;
	localparam logic [31:0] RESET_LENGTH = 32'd65536;

	// Result of one transaction, handed from the sequencer to the output stage
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
		logic [31:0] stored;
	} res_t;

endpackage

// ===== design/ffa_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_table
// Free-range table: one write and one registered read per cycle. Entry 0
// reads from the load registers until it is first written after reset or a load.
// ----------------------------------------------------------------------------
module ffa_table #(
	parameter int TE = 64,
	parameter int AW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [AW-1:0]         load_start,
	input  logic [31:0]           load_len,
	input  logic                  we,
	input  logic [$clog2(TE)-1:0] waddr,
	input  logic [AW-1:0]         wstart,
	input  logic [31:0]           wlen,
	input  logic [$clog2(TE)-1:0] raddr,
	output logic [AW-1:0]         rstart,
	output logic [31:0]           rlen
);
	localparam int IW = $clog2(TE);

	logic [AW-1:0] start_mem [TE];
	logic [31:0]   len_mem [TE];
	logic [AW-1:0] rd_start_q;
	logic [31:0]   rd_len_q;
	logic [AW-1:0] ld_start_q;
	logic [31:0]   ld_len_q;
	logic          pend_q;
	logic          hit_q;

	// Write and read the storage
	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			len_mem[waddr]   <= wlen;
		end
		rd_start_q <= start_mem[raddr];
		rd_len_q   <= len_mem[raddr];
	end

	// Track whether entry 0 still lives in the load registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b1;
			hit_q      <= 1'b0;
			ld_start_q <= '0;
			ld_len_q   <= ffa_pkg::RESET_LENGTH;
		end else begin
			hit_q <= pend_q && (raddr == IW'(0));
			if (load) begin
				pend_q     <= 1'b1;
				ld_start_q <= load_start;
				ld_len_q   <= load_len;
			end else if (we && waddr == IW'(0)) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign rstart = hit_q ? ld_start_q : rd_start_q;
	assign rlen   = hit_q ? ld_len_q : rd_len_q;

endmodule

// ===== design/ffa_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_seq
// Sequencer that scans, merges and shifts the free-range table one entry
// per cycle for allocate and free transactions.
// ----------------------------------------------------------------------------
`include "first_fit_free_list_allocator_macros.svh"

module ffa_seq #(
	parameter int TE = 64,
	parameter int AW = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      mode,
	input  logic [31:0]               request_length,
	input  logic [31:0]               data_address,
	input  logic                      load,
	input  logic                      res_take,
	output logic                      idle,
	output logic                      done,
	output ffa_pkg::res_t             res,
	output logic [$clog2(TE+1)-1:0]   count,
	// table port
	output logic                      we,
	output logic [$clog2(TE)-1:0]     waddr,
	output logic [AW-1:0]             wstart,
	output logic [31:0]               wlen,
	output logic [$clog2(TE)-1:0]     raddr,
	input  logic [AW-1:0]             rstart,
	input  logic [31:0]               rlen
);
	localparam int IW = $clog2(TE);
	localparam int CW = $clog2(TE + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ASCN = 4'd1;
	localparam logic [3:0] S_AADR = 4'd2;
	localparam logic [3:0] S_FPRP = 4'd3;
	localparam logic [3:0] S_FSCN = 4'd4;
	localparam logic [3:0] S_FDEC = 4'd5;
	localparam logic [3:0] S_SHDN = 4'd6;
	localparam logic [3:0] S_SHUP = 4'd7;
	localparam logic [3:0] S_FINS = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [31:0]   req_q, req_d;
	logic [32:0]   need_q, need_d;
	logic [AW-1:0] fstart_q, fstart_d;
	logic [31:0]   flen_q, flen_d;
	logic [AW-1:0] fend_q, fend_d;
	logic [AW-1:0] prev_start_q, prev_start_d;
	logic [31:0]   prev_len_q, prev_len_d;
	logic          prev_ok_q, prev_ok_d;
	logic [31:0]   next_len_q, next_len_d;
	logic          next_hit_q, next_hit_d;
	logic [AW-1:0] cut_start_q, cut_start_d;
	logic [31:0]   rest_q, rest_d;
	logic [1:0]    status_q, status_d;
	logic [AW-1:0] raddr_q, raddr_d;
	logic [31:0]   stored_q, stored_d;

	// Control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CW'(1);
		end else begin
			state_q <= state_d;
			count_q <= load ? CW'(1) : count_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		pos_q        <= pos_d;
		req_q        <= req_d;
		need_q       <= need_d;
		fstart_q     <= fstart_d;
		flen_q       <= flen_d;
		fend_q       <= fend_d;
		prev_start_q <= prev_start_d;
		prev_len_q   <= prev_len_d;
		prev_ok_q    <= prev_ok_d;
		next_len_q   <= next_len_d;
		next_hit_q   <= next_hit_d;
		cut_start_q  <= cut_start_d;
		rest_q       <= rest_d;
		status_q     <= status_d;
		raddr_q      <= raddr_d;
		stored_q     <= stored_d;
	end

	// Step the sequencer
	always_comb begin
		logic [31:0] req_eff;
		logic        with_prev;
		logic        with_next;
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		req_d        = req_q;
		need_d       = need_q;
		fstart_d     = fstart_q;
		flen_d       = flen_q;
		fend_d       = fend_q;
		prev_start_d = prev_start_q;
		prev_len_d   = prev_len_q;
		prev_ok_d    = prev_ok_q;
		next_len_d   = next_len_q;
		next_hit_d   = next_hit_q;
		cut_start_d  = cut_start_q;
		rest_d       = rest_q;
		status_d     = status_q;
		raddr_d      = raddr_q;
		stored_d     = stored_q;
		we           = 1'b0;
		waddr        = '0;
		wstart       = rstart;
		wlen         = rlen;
		raddr        = '0;
		req_eff      = (request_length < ffa_pkg::MIN_REQUEST) ?
			ffa_pkg::MIN_REQUEST : request_length;
		with_prev    = prev_ok_q && ((prev_start_q + AW'(prev_len_q)) == fstart_q);
		with_next    = next_hit_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					status_d = ffa_pkg::ST_OK;
					raddr_d  = '0;
					stored_d = '0;
					idx_d    = '0;
					if (!mode) begin
						req_d  = req_eff;
						need_d = {1'b0, req_eff} + {1'b0, ffa_pkg::HEADER_BYTES};
						if (count_q == CW'(0)) begin
							status_d = ffa_pkg::ST_NOFIT;
							state_d  = S_DONE;
						end else begin
							state_d = S_ASCN;
						end
					end else begin
						fstart_d  = AW'(data_address) - AW'(ffa_pkg::HEADER_BYTES);
						flen_d    = request_length + ffa_pkg::HEADER_BYTES;
						prev_ok_d = 1'b0;
						next_hit_d = 1'b0;
						next_len_d = '0;
						state_d   = S_FPRP;
					end
				end
			end
			// First-fit scan, one entry per cycle
			S_ASCN: begin
				if ({1'b0, rlen} == need_q) begin
					raddr_d  = rstart + AW'(ffa_pkg::HEADER_BYTES);
					stored_d = req_q;
					if (idx_q + CW'(1) < count_q) begin
						raddr   = IW'(idx_q + CW'(1));
						idx_d   = idx_q + CW'(1);
						state_d = S_SHDN;
					end else begin
						count_d = count_q - CW'(1);
						state_d = S_DONE;
					end
				end else if ({1'b0, rlen} > need_q) begin
					we          = 1'b1;
					waddr       = IW'(idx_q);
					wlen        = rlen - need_q[31:0];
					cut_start_d = rstart;
					rest_d      = rlen - req_q;
					stored_d    = req_q;
					state_d     = S_AADR;
				end else if (idx_q + CW'(1) >= count_q) begin
					status_d = ffa_pkg::ST_NOFIT;
					state_d  = S_DONE;
				end else begin
					raddr = IW'(idx_q + CW'(1));
					idx_d = idx_q + CW'(1);
				end
			end
			// Block sits at the top of the shortened range
			S_AADR: begin
				raddr_d = cut_start_q + AW'(rest_q);
				state_d = S_DONE;
			end
			S_FPRP: begin
				fend_d = fstart_q + AW'(flen_q);
				if (count_q == CW'(0)) begin
					pos_d   = '0;
					state_d = S_FDEC;
				end else begin
					state_d = S_FSCN;
				end
			end
			// Find the first entry that starts above the start of the freed range
			S_FSCN: begin
				if (rstart <= fstart_q) begin
					prev_start_d = rstart;
					prev_len_d   = rlen;
					prev_ok_d    = 1'b1;
					if (idx_q + CW'(1) >= count_q) begin
						pos_d   = idx_q + CW'(1);
						state_d = S_FDEC;
					end else begin
						raddr = IW'(idx_q + CW'(1));
						idx_d = idx_q + CW'(1);
					end
				end else begin
					pos_d      = idx_q;
					next_len_d = rlen;
					next_hit_d = (rstart == fend_q);
					state_d    = S_FDEC;
				end
			end
			// Merge with neighbours or prepare the insert
			S_FDEC: begin
				if (with_prev) begin
					we     = 1'b1;
					waddr  = IW'(pos_q - CW'(1));
					wstart = prev_start_q;
					wlen   = prev_len_q + flen_q + (with_next ? next_len_q : 32'd0);
					if (with_next && (pos_q + CW'(1) < count_q)) begin
						raddr   = IW'(pos_q + CW'(1));
						idx_d   = pos_q + CW'(1);
						state_d = S_SHDN;
					end else if (with_next) begin
						count_d = count_q - CW'(1);
						state_d = S_DONE;
					end else begin
						state_d = S_DONE;
					end
				end else if (with_next) begin
					we      = 1'b1;
					waddr   = IW'(pos_q);
					wstart  = fstart_q;
					wlen    = next_len_q + flen_q;
					state_d = S_DONE;
				end else if (count_q >= CW'(TE)) begin
					status_d = ffa_pkg::ST_FULL;
					state_d  = S_DONE;
				end else if (pos_q < count_q) begin
					raddr   = IW'(count_q - CW'(1));
					idx_d   = count_q - CW'(1);
					state_d = S_SHUP;
				end else begin
					state_d = S_FINS;
				end
			end
			// Close the gap: move entry idx down by one
			S_SHDN: begin
				we    = 1'b1;
				waddr = IW'(idx_q - CW'(1));
				if (idx_q + CW'(1) < count_q) begin
					raddr = IW'(idx_q + CW'(1));
					idx_d = idx_q + CW'(1);
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_DONE;
				end
			end
			// Open a gap: move entry idx up by one
			S_SHUP: begin
				we    = 1'b1;
				waddr = IW'(idx_q + CW'(1));
				if (idx_q > pos_q) begin
					raddr = IW'(idx_q - CW'(1));
					idx_d = idx_q - CW'(1);
				end else begin
					state_d = S_FINS;
				end
			end
			S_FINS: begin
				we      = 1'b1;
				waddr   = IW'(pos_q);
				wstart  = fstart_q;
				wlen    = flen_q;
				count_d = count_q + CW'(1);
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign idle        = (state_q == S_IDLE);
	assign done        = (state_q == S_DONE);
	assign count       = count_q;
	assign res.status  = status_q;
	assign res.address = 32'(raddr_q);
	assign res.stored  = stored_q;

	`FFA_ASSERT(a_count_range, count_q <= CW'(TE), "entry count beyond table size")
	`FFA_ASSERT_NEXT(a_start_busy, start && idle, state_q != S_IDLE, "accepted but idle")
	`FFA_ASSERT_NEXT(a_load_one, load, count_q == CW'(1), "reload did not leave one entry")
	`FFA_ASSERT(a_load_idle, !load || idle, "table reload while busy")

endmodule

// ===== design/first_fit_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator
// First-fit allocator over an address-ordered table of free ranges.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: mode 0
//   allocates request_length bytes, mode 1 frees the block at data_address
//   whose header holds request_length. Output channel (out_valid / out_stall)
//   returns status, result_address, stored_length and free_count.
//   The table memory is read and written once a cycle.
//   One transaction is worked at a time; in_stall is high from acceptance
//   until the result is loaded into the output register, and the next
//   transaction can be accepted in the following cycle. If the receiver stalls,
//   the sequencer holds its result until the output register frees up.
//   Reset: region_base 0, one free range of 65536 bytes, no clearing pass.
//   Writing region_length reloads the table as one range at region_base.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator #(
	parameter int TABLE_ENTRIES = 64,
	parameter int ADDRESS_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] request_length,
	input  logic [31:0] data_address,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] result_address,
	output logic [31:0] stored_length,
	output logic [6:0]  free_count
);
	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int AW = ADDRESS_BITS;

	logic [31:0]   base_q;
	logic          load;
	logic          idle;
	logic          done;
	logic          res_take;
	ffa_pkg::res_t res;
	logic [CW-1:0] count;
	logic          we;
	logic [IW-1:0] waddr;
	logic [AW-1:0] wstart;
	logic [31:0]   wlen;
	logic [IW-1:0] raddr;
	logic [AW-1:0] rstart;
	logic [31:0]   rlen;
	logic          out_valid_q;
	ffa_pkg::res_t out_res_q;
	logic [6:0]    out_count_q;

	// Hold the region base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_write && cfg_index == ffa_pkg::REG_BASE) begin
			base_q <= cfg_data;
		end
	end

	assign load     = cfg_write && (cfg_index == ffa_pkg::REG_LENGTH);
	assign in_stall = !idle;
	assign res_take = !out_valid_q || !out_stall;

	ffa_table #(
		.TE (TABLE_ENTRIES),
		.AW (AW)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_start (AW'(base_q)),
		.load_len   (cfg_data),
		.we         (we),
		.waddr      (waddr),
		.wstart     (wstart),
		.wlen       (wlen),
		.raddr      (raddr),
		.rstart     (rstart),
		.rlen       (rlen)
	);

	ffa_seq #(
		.TE (TABLE_ENTRIES),
		.AW (AW)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (in_valid),
		.mode           (mode),
		.request_length (request_length),
		.data_address   (data_address),
		.load           (load),
		.res_take       (res_take),
		.idle           (idle),
		.done           (done),
		.res            (res),
		.count          (count),
		.we             (we),
		.waddr          (waddr),
		.wstart         (wstart),
		.wlen           (wlen),
		.raddr          (raddr),
		.rstart         (rstart),
		.rlen           (rlen)
	);

	// Output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && res_take) begin
			out_res_q   <= res;
			out_count_q <= 7'(count);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_res_q.status;
	assign result_address = out_res_q.address;
	assign stored_length  = out_res_q.stored;
	assign free_count     = out_count_q;

endmodule

// ===== tb/tb_first_fit_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_free_list_allocator
// Self-checking bench for the first-fit free-list allocator. A shadow free
// table predicts every status, address, header length and entry count. The
// bench runs several region settings, a table-full sequence and
// allocate/free traffic with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_first_fit_free_list_allocator;

	localparam int  ENTRIES    = 64;
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct {
		logic        mode;
		logic [31:0] length;
		logic [31:0] address;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] address;
		logic [31:0] stored;
		logic [6:0]  count;
	} outcome_t;

	typedef struct {
		logic [31:0] address;
		logic [31:0] length;
	} block_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic        cfg_index = ffa_pkg::REG_BASE;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = MODE_ALLOC;
	logic [31:0] request_length = '0;
	logic [31:0] data_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] result_address;
	logic [31:0] stored_length;
	logic [6:0]  free_count;

	// shadow free table and region registers
	logic [31:0] shadow_base;
	logic [31:0] shadow_region;
	logic [31:0] range_start [ENTRIES];
	logic [31:0] range_len [ENTRIES];
	int          range_count;

	request_t pending_requests[$];
	outcome_t expected_outcomes[$];
	block_t   live_blocks[$];
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       error_count = 0;

	first_fit_free_list_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.request_length(request_length), .data_address(data_address),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.result_address(result_address), .stored_length(stored_length),
		.free_count(free_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow table
	// ------------------------------------------------------------------
	function automatic void reload_table();
		for (int i = 0; i < ENTRIES; i++) begin
			range_start[i] = '0;
			range_len[i] = '0;
		end
		range_start[0] = shadow_base;
		range_len[0] = shadow_region;
		range_count = 1;
	endfunction

	function automatic void remove_range(int p);
		for (int i = p; i + 1 < range_count; i++) begin
			range_start[i] = range_start[i + 1];
			range_len[i] = range_len[i + 1];
		end
		range_count--;
		range_start[range_count] = '0;
		range_len[range_count] = '0;
	endfunction

	function automatic outcome_t allocate_block(logic [31:0] wanted);
		outcome_t    o;
		logic [31:0] req;
		logic [32:0] need;
		logic [31:0] rest;
		bit          done;
		o = '{ffa_pkg::ST_NOFIT, 32'd0, 32'd0, 7'd0};
		req = (wanted < ffa_pkg::MIN_REQUEST) ? ffa_pkg::MIN_REQUEST : wanted;
		need = {1'b0, req} + {1'b0, ffa_pkg::HEADER_BYTES};
		done = 0;
		for (int i = 0; i < range_count && !done; i++) begin
			if ({1'b0, range_len[i]} == need) begin
				o.status = ffa_pkg::ST_OK;
				o.address = range_start[i] + ffa_pkg::HEADER_BYTES;
				o.stored = req;
				remove_range(i);
				done = 1;
			end else if ({1'b0, range_len[i]} > need) begin
				// cut the block from the top end of the range
				rest = range_len[i] - need[31:0];
				range_len[i] = rest;
				o.status = ffa_pkg::ST_OK;
				o.address = range_start[i] + rest + ffa_pkg::HEADER_BYTES;
				o.stored = req;
				done = 1;
			end
		end
		o.count = 7'(range_count);
		return o;
	endfunction

	function automatic outcome_t return_block(logic [31:0] hdr_len, logic [31:0] data);
		outcome_t    o;
		logic [31:0] start, len, stop;
		int          pos;
		bit          with_prev, with_next;
		o = '{ffa_pkg::ST_OK, 32'd0, 32'd0, 7'd0};
		start = data - ffa_pkg::HEADER_BYTES;
		len = hdr_len + ffa_pkg::HEADER_BYTES;
		stop = start + len;
		pos = 0;
		while (pos < range_count && range_start[pos] <= start) pos++;
		with_prev = pos > 0 && (range_start[pos - 1] + range_len[pos - 1]) == start;
		with_next = pos < range_count && range_start[pos] == stop;
		if (with_prev) begin
			range_len[pos - 1] += len;
			if (with_next) begin
				range_len[pos - 1] += range_len[pos];
				remove_range(pos);
			end
		end else if (with_next) begin
			range_start[pos] = start;
			range_len[pos] += len;
		end else if (range_count >= ENTRIES) begin
			o.status = ffa_pkg::ST_FULL;
		end else begin
			// open a slot at pos and insert
			for (int i = range_count; i > pos; i--) begin
				range_start[i] = range_start[i - 1];
				range_len[i] = range_len[i - 1];
			end
			range_start[pos] = start;
			range_len[pos] = len;
			range_count++;
		end
		o.count = 7'(range_count);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic outcome_t send_alloc(logic [31:0] wanted);
		outcome_t o;
		o = allocate_block(wanted);
		pending_requests.push_back('{MODE_ALLOC, wanted, $urandom});
		expected_outcomes.push_back(o);
		if (o.status == ffa_pkg::ST_OK) live_blocks.push_back('{o.address, o.stored});
		return o;
	endfunction

	function automatic void send_free(logic [31:0] hdr_len, logic [31:0] data);
		pending_requests.push_back('{MODE_FREE, hdr_len, data});
		expected_outcomes.push_back(return_block(hdr_len, data));
	endfunction

	function automatic void free_live(int idx);
		block_t b;
		b = live_blocks[idx];
		live_blocks.delete(idx);
		send_free(b.length, b.address);
	endfunction

	task automatic drain();
		while (pending_requests.size() != 0 || expected_outcomes.size() != 0)
			@(posedge clk);
		// let a possibly busy sequencer settle
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == ffa_pkg::REG_BASE) shadow_base = value;
		else begin
			shadow_region = value;
			reload_table();
		end
	endtask

	task automatic new_phase(int phase, logic [31:0] base, logic [31:0] len);
		drain();
		write_reg(ffa_pkg::REG_BASE, base);
		write_reg(ffa_pkg::REG_LENGTH, len);
		live_blocks.delete();
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
			default: begin send_idle_pct = 16; recv_stall_pct = 16; end
		endcase
	endtask

	task automatic random_traffic(int n);
		int          r;
		logic [31:0] sz;
		outcome_t    o;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 48 || (r < 92 && live_blocks.size() == 0)) begin
				case ($urandom_range(9))
					0:       sz = $urandom_range(512);
					1:       sz = $urandom;
					default: sz = $urandom_range(64);
				endcase
				o = send_alloc(sz);
			end else if (r < 92) begin
				free_live($urandom_range(live_blocks.size() - 1));
			end else if (r < 96) begin
				send_free($urandom, $urandom);
			end else begin
				send_free($urandom_range(64), shadow_base + $urandom_range(4096));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: present one transaction at a time, with random gaps
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				mode <= pending_requests[0].mode;
				request_length <= pending_requests[0].length;
				data_address <= pending_requests[0].address;
				void'(pending_requests.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each result transaction, randomize stall
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					$error("result with no expectation pending");
					error_count++;
				end else begin
					e = expected_outcomes.pop_front();
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						error_count++;
					end
					if (result_address !== e.address) begin
						$error("result_address: expected %h, got %h", e.address,
							result_address);
						error_count++;
					end
					if (stored_length !== e.stored) begin
						$error("stored_length: expected %h, got %h", e.stored,
							stored_length);
						error_count++;
					end
					if (free_count !== e.count) begin
						$error("free_count: expected %0d, got %0d", e.count, free_count);
						error_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		outcome_t a1, a2, a3;
		shadow_base = 32'd0;
		shadow_region = ffa_pkg::RESET_LENGTH;
		reload_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: request extremes and each merge flavor on the reset region
		a1 = send_alloc(32'd0);
		a2 = send_alloc(32'd11);
		a3 = send_alloc(32'd13);
		a1 = send_alloc(32'hFFFF_FFFF);
		a1 = send_alloc(32'hFFFF_FFFC);
		a1 = send_alloc(32'd12);
		free_live(1);
		free_live(2);
		free_live(0);
		send_free(32'd12, 32'd100);
		send_free(32'd12, 32'd100);
		send_free(32'd12, 32'd84);
		send_free(32'hFFFF_FFFF, 32'd0);
		random_traffic(60);

		// region that wraps past the top of the address space; exact fit
		new_phase(1, 32'hFFFF_FF00, 32'h200);
		a1 = send_alloc(32'h1FC);
		a1 = send_alloc(32'd0);
		free_live(0);
		random_traffic(40);

		// empty region
		new_phase(2, 32'h0000_8000, 32'd0);
		a1 = send_alloc(32'd0);
		send_free(32'd12, 32'h0000_8004);
		random_traffic(15);

		// fill the region with minimum blocks, then punch holes until full
		new_phase(3, 32'h0000_1000, 32'd2080);
		for (int i = 0; i < 130; i++) a1 = send_alloc(32'd12);
		a1 = send_alloc(32'd0);
		for (int i = 0; i < 65; i++) free_live(i);
		random_traffic(60);

		// all-ones registers
		new_phase(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_traffic(60);

		// mixed traffic over small random regions
		for (int p = 5; p < 10; p++) begin
			new_phase(p, $urandom, 32'd256 + $urandom_range(4096));
			random_traffic(20);
		end

		drain();
		if (error_count == 0)
			$display("tb_first_fit_free_list_allocator passed");
		else
			$display("tb_first_fit_free_list_allocator failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin
		#40_000_000;
		$display("tb_first_fit_free_list_allocator failed");
		$finish;
	end

endmodule
